// File: sv/bglm_pkg.sv
`timescale 1ns / 1ps

package bglm_pkg;

   localparam int NUM_BANDS    = 4;
   localparam int BAND_W       = 2;
   localparam int SAMPLE_W     = 12;
   localparam int BAR_ROWS     = 8;
   localparam int HEIGHT_W     = 4;
   localparam int MASK_W       = 8;

   // averaging lengths are powers of two, so the means are shifts
   localparam int AVG_SAMPLES  = 4;
   localparam int AVG_SHIFT    = $clog2(AVG_SAMPLES);
   localparam int MCOUNT_W     = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
   localparam int MSUM_W       = SAMPLE_W + AVG_SHIFT;

   localparam int CAL_SAMPLES  = 32;
   localparam int CAL_SHIFT    = $clog2(CAL_SAMPLES);
   localparam int CCOUNT_W     = (CAL_SHIFT > 0) ? CAL_SHIFT : 1;
   localparam int CSUM_W       = SAMPLE_W + CAL_SHIFT;

   localparam int FULL_RANGE   = 550;
   localparam int SCALED_W     = SAMPLE_W + HEIGHT_W;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CSR_IDX_W-1:0] REG_NOISE_MARGIN = 1'b0;
   localparam logic [SAMPLE_W-1:0]  MARGIN_RESET     = 12'd12;

   typedef enum logic {
      OP_MEASURE = 1'b0,
      OP_CLEAR   = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [BAND_W-1:0]   band;
      logic [SAMPLE_W-1:0] mean;
      logic [SAMPLE_W-1:0] zero;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } qstat_type;

endpackage

// File: sv/bglm_front.sv
`timescale 1ns / 1ps

module bglm_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_mode,
   input  logic [bglm_pkg::BAND_W-1:0]        req_band,
   input  logic [bglm_pkg::SAMPLE_W-1:0]      req_sample,
   output logic                               push,
   output bglm_pkg::entry_type                push_entry
);

   logic [bglm_pkg::CSUM_W-1:0]   csum_ff   [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::CSUM_W-1:0]   csum_in   [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::CCOUNT_W-1:0] ccount_ff [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::CCOUNT_W-1:0] ccount_in [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::MSUM_W-1:0]   msum_ff   [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::MSUM_W-1:0]   msum_in   [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::MCOUNT_W-1:0] mcount_ff [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::MCOUNT_W-1:0] mcount_in [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::SAMPLE_W-1:0] zero_ff   [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::SAMPLE_W-1:0] zero_in   [bglm_pkg::NUM_BANDS];

   logic                          accept;
   logic [bglm_pkg::CSUM_W-1:0]   csum_new;
   logic [bglm_pkg::MSUM_W-1:0]   msum_new;

   assign accept = req_valid && !req_stall;

   always_comb begin
      csum_in   = csum_ff;
      ccount_in = ccount_ff;
      msum_in   = msum_ff;
      mcount_in = mcount_ff;
      zero_in   = zero_ff;
      push      = 1'b0;
      csum_new  = csum_ff[req_band] + bglm_pkg::CSUM_W'(req_sample);
      msum_new  = msum_ff[req_band] + bglm_pkg::MSUM_W'(req_sample);
      push_entry.op   = bglm_pkg::OP_MEASURE;
      push_entry.band = req_band;
      push_entry.mean = bglm_pkg::SAMPLE_W'(msum_new >> bglm_pkg::AVG_SHIFT);
      push_entry.zero = zero_ff[req_band];
      if (accept) begin
         if (req_mode) begin
            push_entry.op = bglm_pkg::OP_CLEAR;
            if (ccount_ff[req_band] ==
                bglm_pkg::CCOUNT_W'(bglm_pkg::CAL_SAMPLES - 1)) begin
               zero_in[req_band]   = bglm_pkg::SAMPLE_W'(csum_new >> bglm_pkg::CAL_SHIFT);
               csum_in[req_band]   = '0;
               ccount_in[req_band] = '0;
               push                = 1'b1;
            end else begin
               csum_in[req_band]   = csum_new;
               ccount_in[req_band] = ccount_ff[req_band] + 1'b1;
            end
         end else begin
            if (mcount_ff[req_band] ==
                bglm_pkg::MCOUNT_W'(bglm_pkg::AVG_SAMPLES - 1)) begin
               msum_in[req_band]   = '0;
               mcount_in[req_band] = '0;
               push                = 1'b1;
            end else begin
               msum_in[req_band]   = msum_new;
               mcount_in[req_band] = mcount_ff[req_band] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bglm_pkg::NUM_BANDS; i++) begin
            csum_ff[i]   <= '0;
            ccount_ff[i] <= '0;
            msum_ff[i]   <= '0;
            mcount_ff[i] <= '0;
            zero_ff[i]   <= '0;
         end
      end else begin
         csum_ff   <= csum_in;
         ccount_ff <= ccount_in;
         msum_ff   <= msum_in;
         mcount_ff <= mcount_in;
         zero_ff   <= zero_in;
      end
   end

endmodule

// File: sv/bglm_queue.sv
`timescale 1ns / 1ps

module bglm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bglm_pkg::entry_type  push_entry,
   input  logic                 pop,
   output bglm_pkg::entry_type  head,
   output bglm_pkg::qstat_type  stat
);

   bglm_pkg::entry_type             slot_ff [bglm_pkg::QUEUE_DEPTH];
   logic [bglm_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bglm_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bglm_pkg::QCOUNT_W-1:0]   count_ff, count_in;
   logic                            do_push, do_pop;

   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == bglm_pkg::QCOUNT_W'(bglm_pkg::QUEUE_DEPTH));
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && stat.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == bglm_pkg::QPTR_W'(bglm_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == bglm_pkg::QPTR_W'(bglm_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: sv/bglm_back.sv
`timescale 1ns / 1ps

module bglm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  bglm_pkg::entry_type                head,
   input  bglm_pkg::qstat_type                stat,
   input  logic [bglm_pkg::SAMPLE_W-1:0]      noise_margin,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bglm_pkg::BAND_W-1:0]        rsp_band_out,
   output logic [bglm_pkg::HEIGHT_W-1:0]      rsp_bar_height,
   output logic [bglm_pkg::MASK_W-1:0]        rsp_level_mask
);

   logic [bglm_pkg::HEIGHT_W-1:0]   bar_ff [bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::HEIGHT_W-1:0]   bar_in [bglm_pkg::NUM_BANDS];

   logic                            valid_ff, valid_in;
   logic [bglm_pkg::BAND_W-1:0]     band_ff, band_in;
   logic [bglm_pkg::HEIGHT_W-1:0]   height_ff, height_in;
   logic [bglm_pkg::MASK_W-1:0]     mask_ff, mask_in;

   logic                            out_free;
   logic [bglm_pkg::SAMPLE_W:0]     floor_level;
   logic [bglm_pkg::SAMPLE_W:0]     excess;
   logic [bglm_pkg::SCALED_W-1:0]   scaled;
   logic [bglm_pkg::HEIGHT_W-1:0]   want;
   logic [bglm_pkg::HEIGHT_W-1:0]   cur;
   logic [bglm_pkg::HEIGHT_W-1:0]   top;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = stat.valid && ((head.op == bglm_pkg::OP_CLEAR) || out_free);

   // height from mean less zero level and margin, scaled over the full range
   always_comb begin
      floor_level = {1'b0, head.zero} + {1'b0, noise_margin};
      excess      = {1'b0, head.mean} - floor_level;
      scaled      = bglm_pkg::SCALED_W'(excess) * bglm_pkg::SCALED_W'(bglm_pkg::BAR_ROWS);
      want        = '0;
      if ({1'b0, head.mean} <= floor_level) begin
         want = '0;
      end else if (excess >= (bglm_pkg::SAMPLE_W + 1)'(bglm_pkg::FULL_RANGE)) begin
         want = bglm_pkg::HEIGHT_W'(bglm_pkg::BAR_ROWS);
      end else begin
         want = bglm_pkg::HEIGHT_W'(1);
         for (int k = 1; k < bglm_pkg::BAR_ROWS; k++) begin
            if (scaled >= bglm_pkg::SCALED_W'(bglm_pkg::FULL_RANGE * k)) begin
               want = bglm_pkg::HEIGHT_W'(k + 1);
            end
         end
      end
   end

   always_comb begin
      bar_in = bar_ff;
      cur    = bar_ff[head.band];
      if (pop) begin
         if (head.op == bglm_pkg::OP_CLEAR) begin
            bar_in[head.band] = '0;
         end else if (want >= cur) begin
            bar_in[head.band] = want;
         end else if (cur != '0) begin
            bar_in[head.band] = cur - 1'b1;
         end
      end
      top = '0;
      for (int i = 0; i < bglm_pkg::NUM_BANDS; i++) begin
         if (bar_in[i] > top) begin
            top = bar_in[i];
         end
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      band_in   = band_ff;
      height_in = height_ff;
      mask_in   = mask_ff;
      if (out_free) begin
         valid_in  = pop && (head.op == bglm_pkg::OP_MEASURE);
         band_in   = head.band;
         height_in = bar_in[head.band];
         for (int r = 0; r < bglm_pkg::MASK_W; r++) begin
            mask_in[r] = (top > bglm_pkg::HEIGHT_W'(r));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < bglm_pkg::NUM_BANDS; i++) begin
            bar_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         bar_ff   <= bar_in;
      end
   end

   always_ff @(posedge clock) begin
      band_ff   <= band_in;
      height_ff <= height_in;
      mask_ff   <= mask_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_band_out   = band_ff;
   assign rsp_bar_height = height_ff;
   assign rsp_level_mask = mask_ff;

endmodule

// File: sv/bar_graph_level_meter_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_mode, req_band, req_sample
// rsp       out        rsp_valid/rsp_stall   rsp_band_out, rsp_bar_height, rsp_level_mask
// csr       in         apb-style, pready=1   noise_margin at byte address 0
//
// one sample per cycle while the queue is not full; the front accumulates in the accept cycle and hands
// finished averages and calibration clears to a four-entry queue
// the sample that completes an average pushes its entry into the queue; the back pops it into the output register
// the back pops one entry a cycle while the queue holds one; only a stalled output register holds a measure entry back
// synchronous reset clears all accumulators, zero levels, bars and the queue

module bar_graph_level_meter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [bglm_pkg::BAND_W-1:0]          req_band,
   input  logic [bglm_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bglm_pkg::BAND_W-1:0]          rsp_band_out,
   output logic [bglm_pkg::HEIGHT_W-1:0]        rsp_bar_height,
   output logic [bglm_pkg::MASK_W-1:0]          rsp_level_mask,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bglm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bglm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bglm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [bglm_pkg::SAMPLE_W-1:0]   margin_ff, margin_in;
   logic [bglm_pkg::CSR_IDX_W-1:0]  csr_idx;
   logic                            csr_write;

   logic                            push;
   bglm_pkg::entry_type             push_entry;
   logic                            pop;
   bglm_pkg::entry_type             head;
   bglm_pkg::qstat_type             stat;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[bglm_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      margin_in = margin_ff;
      if (csr_write && (csr_idx == bglm_pkg::REG_NOISE_MARGIN)) begin
         margin_in = csr_pwdata[bglm_pkg::SAMPLE_W-1:0];
      end
      csr_prdata = '0;
      if (csr_idx == bglm_pkg::REG_NOISE_MARGIN) begin
         csr_prdata = bglm_pkg::CSR_DATA_W'(margin_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= bglm_pkg::MARGIN_RESET;
      end else begin
         margin_ff <= margin_in;
      end
   end

   assign req_stall = stat.full;

   bglm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_band   (req_band),
      .req_sample (req_sample),
      .push       (push),
      .push_entry (push_entry)
   );

   bglm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (stat)
   );

   bglm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .stat           (stat),
      .noise_margin   (margin_ff),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_band_out   (rsp_band_out),
      .rsp_bar_height (rsp_bar_height),
      .rsp_level_mask (rsp_level_mask)
   );

   // the level mask is always a thermometer code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_level_mask & (rsp_level_mask + 8'd1)) == 8'd0))
      else $error("level mask not a thermometer code");

   // a band's bar never exceeds the highest bar
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones(rsp_level_mask) >= rsp_bar_height))
      else $error("bar height above the level mask");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bar_height <= bglm_pkg::HEIGHT_W'(bglm_pkg::BAR_ROWS)))
      else $error("bar height out of range");

   // the front never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push)
      else $error("push into full queue");

endmodule

// File: sim/bar_graph_level_meter_top_test.sv
`timescale 1ns / 1ps

module bar_graph_level_meter_top_test;

   localparam logic MODE_MEASURE   = 1'b0;
   localparam logic MODE_CALIBRATE = 1'b1;
   localparam logic [bglm_pkg::CSR_ADDR_W-1:0] MARGIN_ADDR = {bglm_pkg::REG_NOISE_MARGIN, 2'b00};
   localparam int SAMPLE_MAX   = (1 << bglm_pkg::SAMPLE_W) - 1;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_style_type;

   typedef struct packed {
      logic [bglm_pkg::BAND_W-1:0]   band;
      logic [bglm_pkg::HEIGHT_W-1:0] height;
      logic [bglm_pkg::MASK_W-1:0]   mask;
   } bar_update_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_mode;
   logic [bglm_pkg::BAND_W-1:0]     req_band;
   logic [bglm_pkg::SAMPLE_W-1:0]   req_sample;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [bglm_pkg::BAND_W-1:0]     rsp_band_out;
   logic [bglm_pkg::HEIGHT_W-1:0]   rsp_bar_height;
   logic [bglm_pkg::MASK_W-1:0]     rsp_level_mask;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [bglm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bglm_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bglm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // meter state as the block should hold it
   logic [bglm_pkg::CSUM_W-1:0]     cal_total[bglm_pkg::NUM_BANDS];
   int unsigned                     cal_seen[bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::MSUM_W-1:0]     avg_total[bglm_pkg::NUM_BANDS];
   int unsigned                     avg_seen[bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::SAMPLE_W-1:0]   band_zero[bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::HEIGHT_W-1:0]   band_bar[bglm_pkg::NUM_BANDS];
   logic [bglm_pkg::SAMPLE_W-1:0]   margin_setting;

   bar_update_type        queued_bar_updates[$];
   bar_update_type        oldest_update;
   int                    mismatch_count = 0;
   int                    cycle_count = 0;
   int                    burst_left = 0;
   bit                    sender_idling = 1'b0;
   bit                    hold_request = 1'b0;
   int                    hold_count = 0;
   int                    stall_phase = 0;
   stall_style_type       stall_style = STALL_NONE;

   bar_graph_level_meter_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_band       (req_band),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_band_out   (rsp_band_out),
      .rsp_bar_height (rsp_bar_height),
      .rsp_level_mask (rsp_level_mask),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bar_graph_level_meter_top verification failed");
         $finish;
      end
   end

   function automatic logic [bglm_pkg::HEIGHT_W-1:0] bar_for_mean(
         logic [bglm_pkg::SAMPLE_W-1:0] mean, logic [bglm_pkg::SAMPLE_W-1:0] zero);
      int floor_lvl;
      int excess;
      floor_lvl = int'(zero) + int'(margin_setting);
      if (int'(mean) <= floor_lvl)
         return '0;
      excess = int'(mean) - floor_lvl;
      if (excess >= bglm_pkg::FULL_RANGE)
         return bglm_pkg::HEIGHT_W'(bglm_pkg::BAR_ROWS);
      return bglm_pkg::HEIGHT_W'(excess * bglm_pkg::BAR_ROWS / bglm_pkg::FULL_RANGE + 1);
   endfunction

   function automatic logic [bglm_pkg::MASK_W-1:0] thermometer_mask(
         logic [bglm_pkg::HEIGHT_W-1:0] h);
      if (h == 0)
         return '0;
      if (h >= bglm_pkg::MASK_W)
         return '1;
      return bglm_pkg::MASK_W'((1 << h) - 1);
   endfunction

   function automatic logic [bglm_pkg::SAMPLE_W-1:0] clip_sample(int v);
      if (v < 0)
         return '0;
      if (v > SAMPLE_MAX)
         return '1;
      return bglm_pkg::SAMPLE_W'(v);
   endfunction

   task automatic update_meter(logic mode, logic [bglm_pkg::BAND_W-1:0] b,
                               logic [bglm_pkg::SAMPLE_W-1:0] s);
      logic [bglm_pkg::SAMPLE_W-1:0] mean;
      logic [bglm_pkg::HEIGHT_W-1:0] want;
      logic [bglm_pkg::HEIGHT_W-1:0] top;
      bar_update_type                upd;
      if (mode == MODE_CALIBRATE) begin
         cal_total[b] += s;
         cal_seen[b]++;
         if (cal_seen[b] >= bglm_pkg::CAL_SAMPLES) begin
            band_zero[b] = bglm_pkg::SAMPLE_W'(cal_total[b] / bglm_pkg::CAL_SAMPLES);
            band_bar[b]  = '0;
            cal_total[b] = '0;
            cal_seen[b]  = 0;
         end
         return;
      end
      avg_total[b] += s;
      avg_seen[b]++;
      if (avg_seen[b] < bglm_pkg::AVG_SAMPLES)
         return;
      mean = bglm_pkg::SAMPLE_W'(avg_total[b] / bglm_pkg::AVG_SAMPLES);
      avg_total[b] = '0;
      avg_seen[b]  = 0;
      want = bar_for_mean(mean, band_zero[b]);
      if (want >= band_bar[b])
         band_bar[b] = want;
      else if (band_bar[b] > 0)
         band_bar[b]--;
      top = '0;
      for (int k = 0; k < bglm_pkg::NUM_BANDS; k++)
         if (band_bar[k] > top)
            top = band_bar[k];
      upd.band   = b;
      upd.height = band_bar[b];
      upd.mask   = thermometer_mask(top);
      queued_bar_updates.push_back(upd);
   endtask

   task automatic report_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (queued_bar_updates.size() == 0) begin
            report_mismatch("unexpected result band", -1, rsp_band_out);
         end else begin
            oldest_update = queued_bar_updates.pop_front();
            if (rsp_band_out !== oldest_update.band)
               report_mismatch("band_out", oldest_update.band, rsp_band_out);
            if (rsp_bar_height !== oldest_update.height)
               report_mismatch("bar_height", oldest_update.height, rsp_bar_height);
            if (rsp_level_mask !== oldest_update.mask)
               report_mismatch("level_mask", oldest_update.mask, rsp_level_mask);
         end
      end
   end

   // receiver stall pattern and long hold-off
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_count   = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_stall <= 1'b1;
         end else begin
            unique case (stall_style)
               STALL_NONE:    rsp_stall <= 1'b0;
               STALL_RANDOM:  rsp_stall <= ($urandom_range(0, 2) == 0);
               STALL_PATTERN: rsp_stall <= ((stall_phase % 9) < 2) || ((stall_phase % 9) == 5);
            endcase
         end
         stall_phase++;
      end
   end

   task automatic send_sample(logic mode, logic [bglm_pkg::BAND_W-1:0] b,
                              logic [bglm_pkg::SAMPLE_W-1:0] s);
      int gap;
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_band   <= b;
      req_sample <= s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      update_meter(mode, b, s);
      if (sender_idling) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (queued_bar_updates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_transfer(logic wr, logic [bglm_pkg::CSR_DATA_W-1:0] data,
                               output logic [bglm_pkg::CSR_DATA_W-1:0] rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= MARGIN_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_noise_margin(logic [bglm_pkg::SAMPLE_W-1:0] value);
      logic [bglm_pkg::CSR_DATA_W-1:0] rd;
      wait_idle();
      csr_transfer(1'b1, bglm_pkg::CSR_DATA_W'(value), rd);
      margin_setting = value;
      csr_transfer(1'b0, '0, rd);
      if (rd !== bglm_pkg::CSR_DATA_W'(value))
         report_mismatch("noise_margin readback", value, rd);
   endtask

   task automatic measure_group(logic [bglm_pkg::BAND_W-1:0] b, int level, int jitter);
      for (int i = 0; i < bglm_pkg::AVG_SAMPLES; i++)
         send_sample(MODE_MEASURE, b, clip_sample(level + $urandom_range(0, 2 * jitter) - jitter));
   endtask

   task automatic calibrate_band(logic [bglm_pkg::BAND_W-1:0] b, int base, int jitter);
      for (int i = 0; i < bglm_pkg::CAL_SAMPLES; i++)
         send_sample(MODE_CALIBRATE, b,
                     clip_sample(base + $urandom_range(0, 2 * jitter) - jitter));
   endtask

   task automatic test_reset_value();
      logic [bglm_pkg::CSR_DATA_W-1:0] rd;
      csr_transfer(1'b0, '0, rd);
      if (rd !== bglm_pkg::CSR_DATA_W'(bglm_pkg::MARGIN_RESET))
         report_mismatch("noise_margin after reset", bglm_pkg::MARGIN_RESET, rd);
   endtask

   task automatic test_directed();
      sender_idling = 1'b0;
      stall_style   = STALL_NONE;
      measure_group(0, SAMPLE_MAX, 0);
      measure_group(1, 0, 0);
      // falling bar decays by one row
      measure_group(0, 0, 0);
      // calibration sample in the middle of a partial average
      repeat (3) send_sample(MODE_MEASURE, 2, 13);
      send_sample(MODE_CALIBRATE, 2, bglm_pkg::SAMPLE_W'(SAMPLE_MAX));
      send_sample(MODE_MEASURE, 2, 13);
      // mean rounds down onto the silence threshold
      send_sample(MODE_MEASURE, 3, 12);
      send_sample(MODE_MEASURE, 3, 12);
      send_sample(MODE_MEASURE, 3, 12);
      send_sample(MODE_MEASURE, 3, 15);
      // exactly full range above the threshold
      measure_group(1, 562, 0);
      wait_idle();
   endtask

   task automatic test_calibration();
      sender_idling = 1'b1;
      stall_style   = STALL_RANDOM;
      measure_group(0, SAMPLE_MAX, 0);
      // bar of a recalibrated band is cleared and drops out of the mask
      calibrate_band(0, 100, 8);
      measure_group(1, 0, 0);
      calibrate_band(3, SAMPLE_MAX, 0);
      measure_group(3, SAMPLE_MAX, 0);
      calibrate_band(2, 2000, 16);
      for (int i = 0; i < 6; i++)
         measure_group(2, 2000 + bglm_pkg::MARGIN_RESET + $urandom_range(0, 620), 4);
      calibrate_band(1, 0, 0);
      measure_group(1, 300, 8);
      wait_idle();
   endtask

   task automatic test_random_traffic(int n_items, bit idling, stall_style_type style);
      int sent;
      int pick;
      int level;
      int base;
      logic [bglm_pkg::BAND_W-1:0] b;
      sender_idling = idling;
      stall_style   = style;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         b    = bglm_pkg::BAND_W'($urandom_range(0, bglm_pkg::NUM_BANDS - 1));
         if (pick < 3) begin
            base = $urandom_range(0, 9);
            if (base == 0)
               base = 0;
            else if (base == 1)
               base = SAMPLE_MAX;
            else
               base = $urandom_range(0, 2500);
            calibrate_band(b, base, $urandom_range(0, 16));
            sent += bglm_pkg::CAL_SAMPLES;
         end else if (pick < 82) begin
            if ($urandom_range(0, 3) == 0)
               level = $urandom_range(0, SAMPLE_MAX);
            else
               level = int'(band_zero[b]) + int'(margin_setting) + $urandom_range(0, 620);
            measure_group(b, level, $urandom_range(0, 8));
            sent += bglm_pkg::AVG_SAMPLES;
         end else begin
            send_sample(1'($urandom_range(0, 1)), b,
                        bglm_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
            sent++;
         end
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      sender_idling = 1'b0;
      stall_style   = STALL_RANDOM;
      hold_request  = 1'b1;
      for (int i = 0; i < 16; i++)
         measure_group(bglm_pkg::BAND_W'(i % bglm_pkg::NUM_BANDS),
                       $urandom_range(0, SAMPLE_MAX), 20);
      wait_idle();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_mode    <= MODE_MEASURE;
      req_band    <= '0;
      req_sample  <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      margin_setting = bglm_pkg::MARGIN_RESET;
      for (int k = 0; k < bglm_pkg::NUM_BANDS; k++) begin
         cal_total[k] = '0;
         cal_seen[k]  = 0;
         avg_total[k] = '0;
         avg_seen[k]  = 0;
         band_zero[k] = '0;
         band_bar[k]  = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_value();
      test_directed();
      test_calibration();
      set_noise_margin('0);
      test_random_traffic(130, 1'b1, STALL_RANDOM);
      set_noise_margin(bglm_pkg::SAMPLE_W'(SAMPLE_MAX));
      test_random_traffic(80, 1'b1, STALL_PATTERN);
      set_noise_margin(bglm_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
      test_random_traffic(50, 1'b1, STALL_RANDOM);
      set_noise_margin(bglm_pkg::SAMPLE_W'($urandom_range(0, 64)));
      test_backpressure();
      test_random_traffic(90, 1'b1, STALL_PATTERN);
      set_noise_margin(bglm_pkg::MARGIN_RESET);
      test_random_traffic(90, 1'b0, STALL_NONE);

      wait_idle();
      if (mismatch_count == 0)
         $display("bar_graph_level_meter_top verification clean");
      else
         $display("bar_graph_level_meter_top verification failed");
      $finish;
   end

endmodule
